@@ hw/rtl/lsc_pkg.sv @@
// Shared types and constants of the LED strip layer compositor.
package lsc_pkg;

	localparam int LEN_W   = 11;
	localparam int IDX_W   = 10;
	localparam int COL_W   = 8;
	localparam int RGB_W   = 3 * COL_W;
	localparam int EPOCH_W = 8;

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_BLEND = 2'd1,
		REQ_READ  = 2'd2
	} req_t;

	typedef enum logic {
		CFG_STRIP_LENGTH = 1'b0,
		CFG_STRIP_OFFSET = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_SCRUB,
		ST_IDLE,
		ST_DIV,
		ST_DEST,
		ST_MEM
	} state_t;

	// rgb is {red, green, blue}
	typedef struct packed {
		logic [IDX_W-1:0] pixel_index;
		logic [RGB_W-1:0] rgb;
		logic             changed;
	} result_t;

endpackage

@@ hw/rtl/lsc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module lsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/lsc_mod_unit.sv @@
// Restoring remainder unit, one quotient bit per cycle.
module lsc_mod_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [lsc_pkg::LEN_W-1:0] num,
	input  logic [lsc_pkg::LEN_W-1:0] den,
	output logic                     done,
	output logic [lsc_pkg::LEN_W-1:0] rem
);

	localparam int NW = lsc_pkg::LEN_W;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [NW-1:0] den_q;
	logic [NW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [NW:0]   trial;
	logic [NW:0]   diff;
	logic          ge;

	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(NW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CW'(1);
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= num_q << 1;
			rem_q <= ge ? NW'(diff) : NW'(trial);
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ hw/rtl/lsc_out_buf.sv @@
// Two-entry result buffer between the compositor core and the output stream.
module lsc_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lsc_pkg::result_t  din,
	input  logic              pop_ready,
	output logic              valid,
	output lsc_pkg::result_t  dout,
	output logic              room
);

	lsc_pkg::result_t slot_q [2];
	logic [1:0]       count_q;
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic             pop;

	assign valid = count_q != 2'd0;
	assign room  = count_q != 2'd2;
	assign pop   = valid && pop_ready;
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

@@ hw/rtl/led_strip_layer_compositor.sv @@
// Top level of the LED strip layer compositor: control, address maths and display RAM.
//
// Requests arrive on the s_axis channel, one per beat; req_type travels in tuser.
// Every request gives exactly one result beat on m_axis; changed travels in tuser.
// Configuration (strip length, strip offset) is written through cfg_we/cfg_index/
// cfg_wdata; write it only while the block is idle, which the block does not enforce.
// Steps per request, set by the single read-modify-write path through the display RAM:
//   clear, unused code, blend outside its window: result pushed when the request is taken.
//   read: RAM read, then result.
//   blend whose window start matches the last one sent to the remainder unit: address, read, write.
//   blend with a new window start: the remainder unit, then address, read, write.
// A clear bumps an epoch tag held in each RAM entry, so entries of older epochs read
// as black. After reset, and after every 255th clear, a scrub writes every entry
// and no request is taken meanwhile.
// Results queue in a two-entry buffer; a stalled receiver holds the head beat, and the
// block keeps taking requests until the buffer is full.
module led_strip_layer_compositor #(
	parameter int MAX_PIXELS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// step_index[9:0], window_start[19:10], window_length[30:20], reverse_dir[31],
	// or_mode[32], src_red[40:33], src_green[48:41], src_blue[56:49], read_index[66:57]
	input  logic [71:0] s_axis_tdata,
	// req_type[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pixel_index[9:0], out_red[17:10], out_green[25:18], out_blue[33:26]
	output logic [39:0] m_axis_tdata,
	// changed[0]
	output logic        m_axis_tuser,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_wdata
);

	localparam int LW = lsc_pkg::LEN_W;
	localparam int IW = lsc_pkg::IDX_W;
	localparam int CW = lsc_pkg::COL_W;
	localparam int RW = lsc_pkg::RGB_W;
	localparam int EW = lsc_pkg::EPOCH_W;
	localparam int AW = $clog2(MAX_PIXELS);
	localparam int MW = EW + RW;

	lsc_pkg::state_t  state_q, state_d;

	logic [LW-1:0] strip_length_q;
	logic [IW-1:0] strip_offset_q;
	logic [LW-1:0] len_eff;

	logic [AW-1:0] scrub_q;
	logic          scrub_last;
	logic [EW-1:0] epoch_q;

	logic          cache_ok_q;
	logic [IW-1:0] cache_ws_q;
	logic [LW-1:0] cache_start_q;
	logic          cache_hit;

	// request fields
	lsc_pkg::req_t in_req;
	logic [IW-1:0] in_k;
	logic [IW-1:0] in_ws;
	logic [LW-1:0] in_wl;
	logic [LW-1:0] wl_in_eff;
	logic          in_window;
	logic          in_accept;
	logic [IW-1:0] in_read_idx;

	// held request
	logic [IW-1:0] k_q;
	logic [LW-1:0] wl_q;
	logic          rev_q;
	logic          orm_q;
	logic [RW-1:0] src_q;
	logic          is_read_q;
	logic [IW-1:0] read_idx_q;
	logic          read_oor_q;
	logic [LW-1:0] dest_q;

	// destination maths
	logic [LW:0]   fwd_sum;
	logic [LW:0]   end_sum;
	logic [LW-1:0] end_v;
	logic [LW:0]   back_sum;
	logic [LW-1:0] dest_fwd;
	logic [LW-1:0] dest_back;
	logic [LW-1:0] dest;

	// RAM and merge
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [MW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [MW-1:0] ram_rdata;
	logic          tag_hit;
	logic [RW-1:0] old_rgb;
	logic [RW-1:0] new_rgb;
	logic          wrote;
	logic [RW-1:0] read_rgb;

	logic          mod_start;
	logic          mod_done;
	logic [LW-1:0] mod_rem;

	logic              push;
	lsc_pkg::result_t  push_data;
	lsc_pkg::result_t  mem_result;
	lsc_pkg::result_t  out_data;
	logic              buf_room;

	// effective strip length, clamped to 1..MAX_PIXELS
	always_comb begin
		if (strip_length_q == '0) begin
			len_eff = LW'(1);
		end else if (32'(strip_length_q) > MAX_PIXELS) begin
			len_eff = LW'(MAX_PIXELS);
		end else begin
			len_eff = strip_length_q;
		end
	end

	assign in_req      = lsc_pkg::req_t'(s_axis_tuser);
	assign in_k        = s_axis_tdata[9:0];
	assign in_ws       = s_axis_tdata[19:10];
	assign in_wl       = s_axis_tdata[30:20];
	assign in_read_idx = s_axis_tdata[66:57];

	always_comb begin
		if (in_wl == '0) begin
			wl_in_eff = LW'(1);
		end else if (in_wl > len_eff) begin
			wl_in_eff = len_eff;
		end else begin
			wl_in_eff = in_wl;
		end
	end

	assign in_window     = {1'b0, in_k} < wl_in_eff;
	assign cache_hit     = cache_ok_q && (cache_ws_q == in_ws);
	assign s_axis_tready = (state_q == lsc_pkg::ST_IDLE) && buf_room;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign scrub_last    = scrub_q == AW'(MAX_PIXELS - 1);

	// start is below len, and both k and wl-1 are below len, so one subtract wraps each sum
	assign fwd_sum   = {1'b0, cache_start_q} + (LW + 1)'(k_q);
	assign dest_fwd  = (fwd_sum >= {1'b0, len_eff}) ? LW'(fwd_sum - {1'b0, len_eff})
	                                                : LW'(fwd_sum);
	assign end_sum   = {1'b0, cache_start_q} + {1'b0, wl_q} - (LW + 1)'(1);
	assign end_v     = (end_sum >= {1'b0, len_eff}) ? LW'(end_sum - {1'b0, len_eff})
	                                                : LW'(end_sum);
	assign back_sum  = {1'b0, end_v} + {1'b0, len_eff} - (LW + 1)'(k_q);
	assign dest_back = (back_sum >= {1'b0, len_eff}) ? LW'(back_sum - {1'b0, len_eff})
	                                                 : LW'(back_sum);
	assign dest      = rev_q ? dest_back : dest_fwd;

	// merge of the entry read back
	assign tag_hit  = ram_rdata[RW +: EW] == epoch_q;
	assign old_rgb  = tag_hit ? ram_rdata[RW-1:0] : '0;
	assign wrote    = orm_q || (src_q != '0);
	assign new_rgb  = orm_q ? (old_rgb | src_q) : ((src_q != '0) ? src_q : old_rgb);
	assign read_rgb = (tag_hit && !read_oor_q) ? ram_rdata[RW-1:0] : '0;

	always_comb begin
		mem_result = '0;
		if (is_read_q) begin
			mem_result.pixel_index = read_idx_q;
			mem_result.rgb         = read_rgb;
			mem_result.changed     = 1'b0;
		end else begin
			mem_result.pixel_index = dest_q[IW-1:0];
			mem_result.rgb         = new_rgb;
			mem_result.changed     = wrote;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = scrub_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = AW'(in_read_idx);
		push      = 1'b0;
		push_data = '0;
		mod_start = 1'b0;
		unique case (state_q)
			lsc_pkg::ST_SCRUB: begin
				ram_we = 1'b1;
				if (scrub_last) begin
					state_d = lsc_pkg::ST_IDLE;
				end
			end
			lsc_pkg::ST_IDLE: begin
				if (in_accept) begin
					unique case (in_req)
						lsc_pkg::REQ_CLEAR: begin
							push = 1'b1;
							if (epoch_q == '1) begin
								state_d = lsc_pkg::ST_SCRUB;
							end
						end
						lsc_pkg::REQ_BLEND: begin
							if (!in_window) begin
								push = 1'b1;
							end else if (cache_hit) begin
								state_d = lsc_pkg::ST_DEST;
							end else begin
								mod_start = 1'b1;
								state_d   = lsc_pkg::ST_DIV;
							end
						end
						lsc_pkg::REQ_READ: begin
							ram_re  = 1'b1;
							state_d = lsc_pkg::ST_MEM;
						end
						default: begin
							push = 1'b1;
						end
					endcase
				end
			end
			lsc_pkg::ST_DIV: begin
				if (mod_done) begin
					state_d = lsc_pkg::ST_DEST;
				end
			end
			lsc_pkg::ST_DEST: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(dest);
				state_d   = lsc_pkg::ST_MEM;
			end
			lsc_pkg::ST_MEM: begin
				push      = 1'b1;
				push_data = mem_result;
				if (!is_read_q && wrote) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(dest_q);
					ram_wdata = {epoch_q, new_rgb};
				end
				state_d = lsc_pkg::ST_IDLE;
			end
			default: begin
				state_d = lsc_pkg::ST_SCRUB;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsc_pkg::ST_SCRUB;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_length_q <= LW'(1024);
			strip_offset_q <= '0;
			scrub_q        <= '0;
			epoch_q        <= '0;
			cache_ok_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (lsc_pkg::cfg_reg_t'(cfg_index))
					lsc_pkg::CFG_STRIP_LENGTH: strip_length_q <= cfg_wdata;
					lsc_pkg::CFG_STRIP_OFFSET: strip_offset_q <= cfg_wdata[IW-1:0];
				endcase
			end
			if (state_q == lsc_pkg::ST_SCRUB) begin
				scrub_q <= scrub_last ? '0 : scrub_q + AW'(1);
				if (scrub_last) begin
					epoch_q <= EW'(1);
				end
			end else if (in_accept && (in_req == lsc_pkg::REQ_CLEAR) && (epoch_q != '1)) begin
				epoch_q <= epoch_q + EW'(1);
			end
			if (cfg_we) begin
				cache_ok_q <= 1'b0;
			end else if ((state_q == lsc_pkg::ST_DIV) && mod_done) begin
				cache_ok_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			is_read_q  <= in_req == lsc_pkg::REQ_READ;
			read_idx_q <= in_read_idx;
			read_oor_q <= 32'(in_read_idx) >= MAX_PIXELS;
			k_q        <= in_k;
			wl_q       <= wl_in_eff;
			rev_q      <= s_axis_tdata[31];
			orm_q      <= s_axis_tdata[32];
			src_q      <= {s_axis_tdata[40:33], s_axis_tdata[48:41], s_axis_tdata[56:49]};
			if (mod_start) begin
				cache_ws_q <= in_ws;
			end
		end
		if ((state_q == lsc_pkg::ST_DIV) && mod_done) begin
			cache_start_q <= mod_rem;
		end
		if (state_q == lsc_pkg::ST_DEST) begin
			dest_q <= dest;
		end
	end

	lsc_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.num    (LW'(in_ws) + LW'(strip_offset_q)),
		.den    (len_eff),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	lsc_ram #(
		.WIDTH (MW),
		.DEPTH (MAX_PIXELS),
		.AW    (AW)
	) u_display (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lsc_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (push_data),
		.pop_ready (m_axis_tready),
		.valid     (m_axis_tvalid),
		.dout      (out_data),
		.room      (buf_room)
	);

	assign m_axis_tdata = {6'b0, out_data.rgb[CW-1:0], out_data.rgb[2*CW-1:CW],
	                       out_data.rgb[RW-1:2*CW], out_data.pixel_index};
	assign m_axis_tuser = out_data.changed;

`ifndef SYNTHESIS
	// display writes come only from the scrub or the write-back step
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == lsc_pkg::ST_SCRUB || state_q == lsc_pkg::ST_MEM))
		else $error("display write outside scrub or write-back");

	// address step is always followed by the merge step
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lsc_pkg::ST_DEST |=> state_q == lsc_pkg::ST_MEM)
		else $error("address step not followed by merge");

	// epoch zero marks scrubbed entries and must never be live
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != lsc_pkg::ST_SCRUB |-> epoch_q != '0)
		else $error("live epoch equals scrub tag");

	// wrapped destination stays on the strip
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lsc_pkg::ST_DEST |-> dest < len_eff)
		else $error("destination beyond strip length");
`endif

endmodule
